// ----- rtl/pau_pkg.sv -----
`timescale 1ns / 1ps
package pau_pkg;

   localparam int MAX_TERMS = 32;
   localparam int TERM_AW   = $clog2(MAX_TERMS);
   localparam int LEN_W     = TERM_AW + 1;
   localparam int ACC_DEPTH = 2 * MAX_TERMS;
   localparam int ACC_AW    = $clog2(ACC_DEPTH);

   localparam logic [2:0] CMD_APPEND_A = 3'd0;
   localparam logic [2:0] CMD_APPEND_B = 3'd1;
   localparam logic [2:0] CMD_ADD      = 3'd2;
   localparam logic [2:0] CMD_SUB      = 3'd3;
   localparam logic [2:0] CMD_MUL      = 3'd4;
   localparam logic [2:0] CMD_DIV      = 3'd5;

   localparam logic [2:0] ST_OK               = 3'd0;
   localparam logic [2:0] ST_SAT              = 3'd1;
   localparam logic [2:0] ST_EMPTY_DIVISOR    = 3'd2;
   localparam logic [2:0] ST_DIVISOR_LONGER   = 3'd3;
   localparam logic [2:0] ST_ZERO_LOW_TERM    = 3'd4;
   localparam logic [2:0] ST_EMPTY_RESULT     = 3'd5;

   // dividend accumulator clamp, 2^47 - 1
   localparam logic signed [63:0] DLIM = 64'sh0000_7FFF_FFFF_FFFF;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] coeff_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] coeff_out;
      logic [5:0]         term_index;
      logic               last;
      logic [2:0]         status;
   } rsp_type;

   typedef enum logic [2:0] {
      SRC_SUM,
      SRC_ZERO,
      SRC_MAC,
      SRC_DSUB,
      SRC_QUOT
   } src_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_AS_RD,
      S_AS_WR,
      S_MCLR,
      S_M_RD,
      S_M_MUL,
      S_M_ACC,
      S_D_CHK,
      S_D_CHK2,
      S_D_RD,
      S_D_LD,
      S_D_DIV,
      S_D_Q,
      S_D_JRD,
      S_D_JMUL,
      S_D_JWR,
      S_D_QWR,
      S_O_RD,
      S_O_EMIT,
      S_ERR
   } state_type;

   typedef struct packed {
      logic               a_we;
      logic               b_we;
      logic [TERM_AW-1:0] a_addr;
      logic [TERM_AW-1:0] b_addr;
      logic               acc_we;
      logic [ACC_AW-1:0]  acc_raddr;
      logic [ACC_AW-1:0]  acc_waddr;
      src_type            src;
      logic               use_a;
      logic               use_b;
      logic               subtract;
      logic               cap_mul;
      logic               mul_q;
      logic               cap_acc;
      logic               div_load;
      logic               q_form;
      logic               emit;
      logic               round;
      logic [ACC_AW-1:0]  index;
      logic               last;
      logic               err_emit;
      logic [2:0]         err_code;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic b_zero;
   } dp_stat_type;

   // Q32.32 to Q16.16: add half an LSB, floor
   function automatic logic signed [63:0] round16(input logic signed [63:0] x);
      return (x >>> 16) + $signed({63'd0, x[15]});
   endfunction

endpackage

// ----- rtl/pau_ram.sv -----
`timescale 1ns / 1ps
module pau_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/pau_dp.sv -----
`timescale 1ns / 1ps
module pau_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic signed [31:0]  coeff,
   input  pau_pkg::dp_cmd_type cmd,
   output pau_pkg::dp_stat_type stat,
   output pau_pkg::rsp_type    rsp,
   output logic                rsp_strobe
);
   import pau_pkg::*;

   logic signed [31:0] a_rd, b_rd;
   logic [64:0]        acc_rd;
   logic [64:0]        acc_wd;
   logic signed [63:0] acc_val;
   logic               acc_sat;

   pau_ram #(.WIDTH(32), .DEPTH(MAX_TERMS)) u_ram_a (
      .clock, .we(cmd.a_we), .waddr(cmd.a_addr), .wdata(coeff),
      .raddr(cmd.a_addr), .rdata(a_rd));

   pau_ram #(.WIDTH(32), .DEPTH(MAX_TERMS)) u_ram_b (
      .clock, .we(cmd.b_we), .waddr(cmd.b_addr), .wdata(coeff),
      .raddr(cmd.b_addr), .rdata(b_rd));

   // accumulator word: {sat, value}
   pau_ram #(.WIDTH(65), .DEPTH(ACC_DEPTH)) u_ram_acc (
      .clock, .we(cmd.acc_we), .waddr(cmd.acc_waddr), .wdata(acc_wd),
      .raddr(cmd.acc_raddr), .rdata(acc_rd));

   assign acc_val = $signed(acc_rd[63:0]);
   assign acc_sat = acc_rd[64];

   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] accd_ff;
   logic               accs_ff;
   logic signed [31:0] q_ff, q_in;
   logic               qs_ff, qs_in;
   logic signed [31:0] mul_x;

   assign mul_x   = cmd.mul_q ? q_ff : a_rd;
   assign prod_in = mul_x * b_rd;

   always_ff @(posedge clock) begin
      if (cmd.cap_mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.cap_acc) begin
         accd_ff <= acc_val;
         accs_ff <= acc_sat;
      end
      if (cmd.q_form) begin
         q_ff  <= q_in;
         qs_ff <= qs_in;
      end
   end

   // restoring divider, one quotient bit per cycle on magnitudes
   logic [31:0] rem_ff, rem_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] dsr_ff;
   logic [6:0]  cnt_ff, cnt_in;
   logic        neg_ff;
   logic        dsat_ff;
   logic [32:0] rem_sh;
   logic [63:0] d_abs;

   assign d_abs  = acc_val[63] ? 64'(-acc_val) : 64'(acc_val);
   assign rem_sh = {rem_ff, dvd_ff[63]};

   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (cmd.div_load) begin
         rem_in = '0;
         dvd_in = d_abs << 16;
         quo_in = '0;
         cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         dvd_in = {dvd_ff[62:0], 1'b0};
         cnt_in = cnt_ff - 7'd1;
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = 32'(rem_sh - {1'b0, dsr_ff});
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      if (cmd.div_load) begin
         dsr_ff  <= b_rd[31] ? 32'(-b_rd) : 32'(b_rd);
         neg_ff  <= acc_val[63] ^ b_rd[31];
         dsat_ff <= acc_sat;
      end
   end

   assign stat.div_done = (cnt_ff == 7'd0);
   assign stat.b_zero   = (b_rd == 32'sd0);

   // quotient sign and 32-bit saturation
   always_comb begin
      qs_in = dsat_ff;
      if (neg_ff) begin
         if (quo_ff > 64'h0000_0000_8000_0000) begin
            q_in  = 32'sh8000_0000;
            qs_in = 1'b1;
         end else begin
            q_in = $signed(32'(-quo_ff[31:0]));
         end
      end else begin
         if (quo_ff > 64'h0000_0000_7FFF_FFFF) begin
            q_in  = 32'sh7FFF_FFFF;
            qs_in = 1'b1;
         end else begin
            q_in = $signed(quo_ff[31:0]);
         end
      end
   end

   // accumulator write data
   logic signed [63:0] a_term, b_term, mac_sum, p_rnd, diff;

   assign a_term  = cmd.use_a ? 64'(a_rd) : 64'sd0;
   assign b_term  = cmd.use_b ? 64'(b_rd) : 64'sd0;
   assign mac_sum = accd_ff + prod_ff;
   assign p_rnd   = round16(prod_ff);
   assign diff    = accd_ff - p_rnd;

   always_comb begin
      unique case (cmd.src)
         SRC_SUM: begin
            acc_wd = {1'b0, cmd.subtract ? (a_term - b_term) : (a_term + b_term)};
         end
         SRC_ZERO: begin
            acc_wd = '0;
         end
         SRC_MAC: begin
            if (!accd_ff[63] && !prod_ff[63] && mac_sum[63]) begin
               acc_wd = {1'b1, 64'h7FFF_FFFF_FFFF_FFFF};
            end else if (accd_ff[63] && prod_ff[63] && !mac_sum[63]) begin
               acc_wd = {1'b1, 64'h8000_0000_0000_0000};
            end else begin
               acc_wd = {accs_ff, mac_sum};
            end
         end
         SRC_DSUB: begin
            if (diff > DLIM) begin
               acc_wd = {1'b1, DLIM};
            end else if (diff < -DLIM) begin
               acc_wd = {1'b1, -DLIM};
            end else begin
               acc_wd = {accs_ff, diff};
            end
         end
         SRC_QUOT: begin
            acc_wd = {qs_ff, 64'(q_ff)};
         end
         default: begin
            acc_wd = '0;
         end
      endcase
   end

   // result word
   logic signed [63:0] out_val;
   rsp_type            rsp_ff, rsp_in;
   logic               strobe_ff;

   assign out_val = cmd.round ? round16(acc_val) : acc_val;

   always_comb begin
      rsp_in            = rsp_ff;
      rsp_in.term_index = 6'(cmd.index);
      rsp_in.last       = cmd.last;
      rsp_in.status     = acc_sat ? ST_SAT : ST_OK;
      if (out_val > 64'sd2147483647) begin
         rsp_in.coeff_out = 32'sh7FFF_FFFF;
         rsp_in.status    = ST_SAT;
      end else if (out_val < -64'sd2147483648) begin
         rsp_in.coeff_out = 32'sh8000_0000;
         rsp_in.status    = ST_SAT;
      end else begin
         rsp_in.coeff_out = out_val[31:0];
      end
      if (cmd.err_emit) begin
         rsp_in.coeff_out  = '0;
         rsp_in.term_index = '0;
         rsp_in.last       = 1'b1;
         rsp_in.status     = cmd.err_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit | cmd.err_emit;
      end
      if (cmd.emit | cmd.err_emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp        = rsp_ff;
   assign rsp_strobe = strobe_ff;

endmodule

// ----- rtl/pau_ctrl.sv -----
`timescale 1ns / 1ps
module pau_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [2:0]           req_cmd,
   output logic                 busy,
   output pau_pkg::dp_cmd_type  cmd,
   input  pau_pkg::dp_stat_type stat
);
   import pau_pkg::*;

   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   la_ff, la_in, lb_ff, lb_in;
   logic [LEN_W-1:0]   opa_ff, opa_in, opb_ff, opb_in;
   logic [2:0]         op_ff, op_in;
   logic [ACC_AW-1:0]  n_ff, n_in, k_ff, k_in;
   logic [LEN_W-1:0]   i_ff, i_in, j_ff, j_in;
   logic [2:0]         err_ff, err_in;

   logic [ACC_AW-1:0]  k_nx, lim, ij;
   logic [LEN_W-1:0]   i_nx, j_nx, len_max;
   logic               a_room, b_room;

   assign k_nx    = k_ff + ACC_AW'(1);
   assign i_nx    = i_ff + LEN_W'(1);
   assign j_nx    = j_ff + LEN_W'(1);
   assign ij      = ACC_AW'(i_ff) + ACC_AW'(j_ff);
   assign lim     = (op_ff == CMD_DIV) ? ACC_AW'(opa_ff) : n_ff;
   assign len_max = (la_ff > lb_ff) ? la_ff : lb_ff;
   assign a_room  = la_ff < LEN_W'(MAX_TERMS);
   assign b_room  = lb_ff < LEN_W'(MAX_TERMS);
   assign busy    = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      la_in    = la_ff;
      lb_in    = lb_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      op_in    = op_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      err_in   = err_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_APPEND_A) begin
                  if (a_room) la_in = la_ff + LEN_W'(1);
               end else if (req_cmd == CMD_APPEND_B) begin
                  if (b_room) lb_in = lb_ff + LEN_W'(1);
               end else if (req_cmd == CMD_ADD || req_cmd == CMD_SUB ||
                            req_cmd == CMD_MUL || req_cmd == CMD_DIV) begin
                  la_in  = '0;
                  lb_in  = '0;
                  opa_in = la_ff;
                  opb_in = lb_ff;
                  op_in  = req_cmd;
                  k_in   = '0;
                  i_in   = '0;
                  j_in   = '0;
                  if (req_cmd == CMD_ADD || req_cmd == CMD_SUB) begin
                     n_in = ACC_AW'(len_max);
                     if (len_max == '0) begin
                        err_in   = ST_EMPTY_RESULT;
                        state_in = S_ERR;
                     end else begin
                        state_in = S_AS_RD;
                     end
                  end else if (req_cmd == CMD_MUL) begin
                     n_in = ACC_AW'({1'b0, la_ff} + {1'b0, lb_ff} - 1'b1);
                     if (la_ff == '0 || lb_ff == '0) begin
                        err_in   = ST_EMPTY_RESULT;
                        state_in = S_ERR;
                     end else begin
                        state_in = S_MCLR;
                     end
                  end else begin
                     n_in = ACC_AW'(la_ff - lb_ff + LEN_W'(1));
                     if (lb_ff == '0) begin
                        err_in   = ST_EMPTY_DIVISOR;
                        state_in = S_ERR;
                     end else if (la_ff < lb_ff) begin
                        err_in   = ST_DIVISOR_LONGER;
                        state_in = S_ERR;
                     end else begin
                        state_in = S_D_CHK;
                     end
                  end
               end
            end
         end
         S_AS_RD: state_in = S_AS_WR;
         S_AS_WR: begin
            if (k_nx == lim) begin
               k_in     = '0;
               i_in     = '0;
               state_in = (op_ff == CMD_DIV) ? S_D_RD : S_O_RD;
            end else begin
               k_in     = k_nx;
               state_in = S_AS_RD;
            end
         end
         S_MCLR: begin
            if (k_nx == n_ff) begin
               k_in     = '0;
               state_in = S_M_RD;
            end else begin
               k_in = k_nx;
            end
         end
         S_M_RD:  state_in = S_M_MUL;
         S_M_MUL: state_in = S_M_ACC;
         S_M_ACC: begin
            state_in = S_M_RD;
            if (j_nx == opb_ff) begin
               j_in = '0;
               if (i_nx == opa_ff) begin
                  k_in     = '0;
                  state_in = S_O_RD;
               end else begin
                  i_in = i_nx;
               end
            end else begin
               j_in = j_nx;
            end
         end
         S_D_CHK: state_in = S_D_CHK2;
         S_D_CHK2: begin
            if (stat.b_zero) begin
               err_in   = ST_ZERO_LOW_TERM;
               state_in = S_ERR;
            end else begin
               k_in     = '0;
               state_in = S_AS_RD;
            end
         end
         S_D_RD: state_in = S_D_LD;
         S_D_LD: state_in = S_D_DIV;
         S_D_DIV: begin
            if (stat.div_done) state_in = S_D_Q;
         end
         S_D_Q: begin
            j_in     = '0;
            state_in = S_D_JRD;
         end
         S_D_JRD:  state_in = S_D_JMUL;
         S_D_JMUL: state_in = S_D_JWR;
         S_D_JWR: begin
            if (j_nx == opb_ff) begin
               state_in = S_D_QWR;
            end else begin
               j_in     = j_nx;
               state_in = S_D_JRD;
            end
         end
         S_D_QWR: begin
            if (ACC_AW'(i_nx) == n_ff) begin
               k_in     = '0;
               state_in = S_O_RD;
            end else begin
               i_in     = i_nx;
               state_in = S_D_RD;
            end
         end
         S_O_RD: state_in = S_O_EMIT;
         S_O_EMIT: begin
            if (k_nx == n_ff) begin
               state_in = S_IDLE;
            end else begin
               k_in     = k_nx;
               state_in = S_O_RD;
            end
         end
         S_ERR:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.src       = SRC_SUM;
      cmd.a_addr    = TERM_AW'(k_ff);
      cmd.b_addr    = TERM_AW'(k_ff);
      cmd.acc_raddr = k_ff;
      cmd.acc_waddr = k_ff;
      cmd.index     = k_ff;
      cmd.err_code  = err_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.a_addr = TERM_AW'(la_ff);
            cmd.b_addr = TERM_AW'(lb_ff);
            cmd.a_we   = start && (req_cmd == CMD_APPEND_A) && a_room;
            cmd.b_we   = start && (req_cmd == CMD_APPEND_B) && b_room;
         end
         S_AS_WR: begin
            cmd.acc_we   = 1'b1;
            cmd.src      = SRC_SUM;
            cmd.use_a    = k_ff < ACC_AW'(opa_ff);
            cmd.use_b    = (op_ff != CMD_DIV) && (k_ff < ACC_AW'(opb_ff));
            cmd.subtract = (op_ff == CMD_SUB);
         end
         S_MCLR: begin
            cmd.acc_we = 1'b1;
            cmd.src    = SRC_ZERO;
         end
         S_M_RD: begin
            cmd.a_addr    = TERM_AW'(i_ff);
            cmd.b_addr    = TERM_AW'(j_ff);
            cmd.acc_raddr = ij;
         end
         S_M_MUL: begin
            cmd.cap_mul = 1'b1;
            cmd.cap_acc = 1'b1;
         end
         S_M_ACC: begin
            cmd.acc_we    = 1'b1;
            cmd.acc_waddr = ij;
            cmd.src       = SRC_MAC;
         end
         S_D_CHK, S_D_CHK2: begin
            cmd.b_addr = '0;
         end
         S_D_RD, S_D_LD: begin
            cmd.b_addr    = '0;
            cmd.acc_raddr = ACC_AW'(i_ff);
            cmd.div_load  = (state_ff == S_D_LD);
         end
         S_D_Q: begin
            cmd.q_form = 1'b1;
         end
         S_D_JRD: begin
            cmd.b_addr    = TERM_AW'(j_ff);
            cmd.acc_raddr = ij;
         end
         S_D_JMUL: begin
            cmd.mul_q   = 1'b1;
            cmd.cap_mul = 1'b1;
            cmd.cap_acc = 1'b1;
         end
         S_D_JWR: begin
            cmd.acc_we    = 1'b1;
            cmd.acc_waddr = ij;
            cmd.src       = SRC_DSUB;
         end
         S_D_QWR: begin
            // dividend term i is dead now, reuse its slot for the quotient
            cmd.acc_we    = 1'b1;
            cmd.acc_waddr = ACC_AW'(i_ff);
            cmd.src       = SRC_QUOT;
         end
         S_O_EMIT: begin
            cmd.emit  = 1'b1;
            cmd.round = (op_ff == CMD_MUL);
            cmd.last  = (k_nx == n_ff);
         end
         S_ERR: begin
            cmd.err_emit = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         la_ff    <= '0;
         lb_ff    <= '0;
         opa_ff   <= '0;
         opb_ff   <= '0;
         op_ff    <= '0;
         n_ff     <= '0;
         k_ff     <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         err_ff   <= '0;
      end else begin
         state_ff <= state_in;
         la_ff    <= la_in;
         lb_ff    <= lb_in;
         opa_ff   <= opa_in;
         opb_ff   <= opb_in;
         op_ff    <= op_in;
         n_ff     <= n_in;
         k_ff     <= k_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         err_ff   <= err_in;
      end
   end

endmodule

// ----- rtl/polynomial_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// Channel   Ports                      Handshake
// request   req_data (cmd, coeff_in)   taken on start && !busy
// response  rsp_data (coeff, index,    one cycle per word on rsp_strobe,
//           last, status)              no backpressure
//
// Append words are taken back to back and do not raise busy. A compute word holds busy
// while it runs: add/subtract reads and writes each result term, then emits them; multiply
// clears the n result slots, does one MAC per pair of terms (la*lb of them), then emits;
// divide runs the one-bit-per-cycle divider and an lb-term update per quotient term.
// Synchronous reset empties both operands; RAM contents are not cleared.
module polynomial_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pau_pkg::req_type req_data,
   output pau_pkg::rsp_type rsp_data,
   output logic             rsp_strobe
);
   import pau_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   pau_ctrl u_ctrl (
      .clock,
      .reset,
      .start,
      .req_cmd (req_data.cmd),
      .busy,
      .cmd     (dp_cmd),
      .stat    (dp_stat)
   );

   pau_dp u_dp (
      .clock,
      .reset,
      .coeff      (req_data.coeff_in),
      .cmd        (dp_cmd),
      .stat       (dp_stat),
      .rsp        (rsp_data),
      .rsp_strobe
   );

endmodule

// ----- bench/polynomial_arithmetic_unit_test.sv -----
`timescale 1ns / 1ps
module polynomial_arithmetic_unit_test;
   import pau_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int RANDOM_WORDS = 240;
   localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] I32_MIN = -64'sd2147483648;
   localparam logic signed [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] I64_MIN = 64'h8000_0000_0000_0000;
   localparam logic [2:0] CMD_BAD = 3'd6;

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_data = '0;
   rsp_type rsp_data;
   logic    rsp_strobe;

   polynomial_arithmetic_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_data(rsp_data), .rsp_strobe(rsp_strobe)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // predictor state
   logic signed [31:0] poly_a [MAX_TERMS];
   logic signed [31:0] poly_b [MAX_TERMS];
   int len_a = 0, len_b = 0;
   rsp_type expected_words [$];
   int errors = 0, cycles = 0, words_sent = 0, words_seen = 0;
   int computes = 0, sat_seen = 0;
   bit driving = 0;

   function automatic rsp_type make_word(logic signed [31:0] c, int idx, bit lst,
                                         logic [2:0] st);
      rsp_type w;
      w.coeff_out = c;
      w.term_index = idx[5:0];
      w.last = lst;
      w.status = st;
      return w;
   endfunction

   function automatic logic signed [63:0] q16_round(logic signed [63:0] x);
      logic signed [63:0] fl;
      fl = x >>> 16;
      return fl + {63'd0, x[15]};
   endfunction

   task automatic push_term(logic signed [63:0] v, bit flag, int idx, bit lst);
      logic signed [31:0] c;
      if (v > I32_MAX) begin c = I32_MAX[31:0]; flag = 1; end
      else if (v < I32_MIN) begin c = I32_MIN[31:0]; flag = 1; end
      else c = v[31:0];
      expected_words.push_back(make_word(c, idx, lst, flag ? ST_SAT : ST_OK));
   endtask

   task automatic predict_word(req_type w);
      logic signed [63:0] acc [ACC_DEPTH];
      bit sat [ACC_DEPTH];
      logic signed [63:0] quo [MAX_TERMS];
      bit qsat [MAX_TERMS];
      logic signed [63:0] s, p, d, b0;
      int la, lb, n;
      la = len_a;
      lb = len_b;
      n = 0;
      if (w.cmd == CMD_APPEND_A) begin
         if (len_a < MAX_TERMS) begin poly_a[len_a] = w.coeff_in; len_a++; end
         return;
      end
      if (w.cmd == CMD_APPEND_B) begin
         if (len_b < MAX_TERMS) begin poly_b[len_b] = w.coeff_in; len_b++; end
         return;
      end
      if (w.cmd > CMD_DIV) return;
      computes++;
      len_a = 0;
      len_b = 0;
      for (int i = 0; i < ACC_DEPTH; i++) begin acc[i] = 0; sat[i] = 0; end
      case (w.cmd)
         CMD_ADD, CMD_SUB: begin
            n = la > lb ? la : lb;
            for (int i = 0; i < n; i++) begin
               s = i < la ? 64'(poly_a[i]) : 64'sd0;
               p = i < lb ? 64'(poly_b[i]) : 64'sd0;
               acc[i] = w.cmd == CMD_ADD ? s + p : s - p;
            end
         end
         CMD_MUL: begin
            if (la == 0 || lb == 0) begin
               expected_words.push_back(make_word(0, 0, 1, ST_EMPTY_RESULT));
               return;
            end
            n = la + lb - 1;
            for (int i = 0; i < la; i++)
               for (int j = 0; j < lb; j++) begin
                  p = 64'(poly_a[i]) * 64'(poly_b[j]);
                  s = acc[i+j] + p;
                  if (!acc[i+j][63] && !p[63] && s[63]) begin
                     s = I64_MAX; sat[i+j] = 1;
                  end else if (acc[i+j][63] && p[63] && !s[63]) begin
                     s = I64_MIN; sat[i+j] = 1;
                  end
                  acc[i+j] = s;
               end
            for (int i = 0; i < n; i++) acc[i] = q16_round(acc[i]);
         end
         default: begin
            if (lb == 0) begin
               expected_words.push_back(make_word(0, 0, 1, ST_EMPTY_DIVISOR));
               return;
            end
            if (la < lb) begin
               expected_words.push_back(make_word(0, 0, 1, ST_DIVISOR_LONGER));
               return;
            end
            b0 = 64'(poly_b[0]);
            if (b0 == 0) begin
               expected_words.push_back(make_word(0, 0, 1, ST_ZERO_LOW_TERM));
               return;
            end
            n = la - lb + 1;
            for (int i = 0; i < la; i++) acc[i] = 64'(poly_a[i]);
            for (int i = 0; i < n; i++) begin
               qsat[i] = sat[i];
               s = (acc[i] * 64'sd65536) / b0;
               if (s > I32_MAX) begin s = I32_MAX; qsat[i] = 1; end
               else if (s < I32_MIN) begin s = I32_MIN; qsat[i] = 1; end
               quo[i] = s;
               for (int j = 0; j < lb; j++) begin
                  p = q16_round(s * 64'(poly_b[j]));
                  d = acc[i+j] - p;
                  if (d > DLIM) begin d = DLIM; sat[i+j] = 1; end
                  else if (d < -DLIM) begin d = -DLIM; sat[i+j] = 1; end
                  acc[i+j] = d;
               end
            end
            for (int i = 0; i < n; i++) begin acc[i] = quo[i]; sat[i] = qsat[i]; end
         end
      endcase
      if (n == 0) begin
         expected_words.push_back(make_word(0, 0, 1, ST_EMPTY_RESULT));
         return;
      end
      for (int k = 0; k < n; k++) push_term(acc[k], sat[k], k, k == n - 1);
   endtask

   task automatic report(string msg);
      errors++;
      $display("MISMATCH %s", msg);
   endtask

   task automatic report_mismatch(string what, rsp_type got, rsp_type want);
      report($sformatf("%s: got c=%h i=%0d l=%0d s=%0d want c=%h i=%0d l=%0d s=%0d",
                       what, got.coeff_out, got.term_index, got.last, got.status,
                       want.coeff_out, want.term_index, want.last, want.status));
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_strobe) begin
         words_seen++;
         if (rsp_data.status == ST_SAT) sat_seen++;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected word c=%h i=%0d", rsp_data.coeff_out,
                             rsp_data.term_index));
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.coeff_out !== want.coeff_out) report_mismatch("coeff", rsp_data, want);
            else if (rsp_data.term_index !== want.term_index)
               report_mismatch("index", rsp_data, want);
            else if (rsp_data.last !== want.last) report_mismatch("last", rsp_data, want);
            else if (rsp_data.status !== want.status) report_mismatch("status", rsp_data, want);
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d words outstanding", expected_words.size());
         $display("polynomial_arithmetic_unit test failed");
         $finish;
      end
   end

   // start stays high between back-to-back words; dropped only before a pause
   task automatic quiet();
      if (driving) begin
         start <= 0;
         driving = 0;
      end
   endtask

   task automatic send_word(logic [2:0] cmd, logic signed [31:0] coeff);
      req_type w;
      w.cmd = cmd;
      w.coeff_in = coeff;
      start <= 1;
      req_data <= w;
      driving = 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_word(w);
      words_sent++;
   endtask

   task automatic idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return;
      quiet();
      repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(8, 40)) @(posedge clock);
   endtask

   task automatic drain();
      quiet();
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coeff(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
         2: return $urandom_range(0, 3) == 0 ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return 32'($urandom_range(1, 4)) << 16;
      endcase
   endfunction

   typedef struct {
      logic [2:0]         cmd;
      logic signed [31:0] coeff;
      bit                 typed;
      logic [2:0]         st;
   } step_type;

   step_type steps [24] = '{
      '{CMD_ADD, 0, 1, ST_EMPTY_RESULT},       // nothing loaded after reset
      '{CMD_MUL, 0, 1, ST_EMPTY_RESULT},
      '{CMD_DIV, 0, 1, ST_EMPTY_DIVISOR},
      '{CMD_APPEND_B, 32'sh10000, 0, ST_OK},
      '{CMD_DIV, 0, 1, ST_DIVISOR_LONGER},
      '{CMD_APPEND_A, 32'sh10000, 0, ST_OK},
      '{CMD_APPEND_B, 0, 0, ST_OK},
      '{CMD_DIV, 0, 1, ST_ZERO_LOW_TERM},
      '{CMD_APPEND_A, 32'sh7FFFFFFF, 0, ST_OK},
      '{CMD_APPEND_B, 32'sh7FFFFFFF, 0, ST_OK},
      '{CMD_ADD, 0, 0, ST_OK},                 // saturates high
      '{CMD_APPEND_A, 32'sh80000000, 0, ST_OK},
      '{CMD_APPEND_B, 32'sh7FFFFFFF, 0, ST_OK},
      '{CMD_SUB, 0, 0, ST_OK},
      '{CMD_APPEND_A, 32'sh80000000, 0, ST_OK},
      '{CMD_APPEND_A, 32'sh00030000, 0, ST_OK},
      '{CMD_APPEND_B, 32'sh80000000, 0, ST_OK},
      '{CMD_MUL, 0, 0, ST_OK},
      '{CMD_BAD, 32'sh1234, 0, ST_OK},         // ignored
      '{CMD_APPEND_A, 32'sh00020000, 0, ST_OK},
      '{CMD_APPEND_A, 32'sh00050000, 0, ST_OK},
      '{CMD_APPEND_B, 32'sh00010000, 0, ST_OK},
      '{CMD_APPEND_B, 32'sh00008000, 0, ST_OK},
      '{CMD_DIV, 0, 0, ST_OK}
   };

   initial begin
      int kind, la, lb, mode, sent;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (steps[i]) begin
         send_word(steps[i].cmd, steps[i].coeff);
         if (steps[i].typed && (expected_words.size() == 0 ||
             expected_words[$].status !== steps[i].st)) begin
            report($sformatf("directed row %0d expected status %0d", i, steps[i].st));
         end
         idle_gap();
      end
      // full operands: appends past the limit are dropped
      for (int i = 0; i < MAX_TERMS + 2; i++) send_word(CMD_APPEND_A, rand_coeff(0));
      for (int i = 0; i < MAX_TERMS + 1; i++) send_word(CMD_APPEND_B, rand_coeff(1));
      send_word(CMD_MUL, 0);
      drain();
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         kind = $urandom_range(0, 9);
         mode = $urandom_range(0, 3);
         if (kind == 0) begin
            send_word(3'($urandom_range(0, 7)), $urandom);
            sent++;
         end else begin
            la = $urandom_range(0, 99) < 90 ? $urandom_range(0, 6) : $urandom_range(0, 33);
            lb = $urandom_range(0, 99) < 90 ? $urandom_range(0, 5) : $urandom_range(0, 33);
            for (int i = 0; i < la; i++) begin
               send_word(CMD_APPEND_A, rand_coeff(mode)); sent++; idle_gap();
            end
            for (int i = 0; i < lb; i++) begin
               send_word(CMD_APPEND_B,
                         i == 0 && mode == 3 ? 32'sh10000 : rand_coeff(mode));
               sent++; idle_gap();
            end
            send_word(3'($urandom_range(CMD_ADD, CMD_DIV)), $urandom);
            sent++;
         end
         if ($urandom_range(0, 29) == 0) drain();
         idle_gap();
      end
      drain();
      repeat (200) @(posedge clock);
      $display("sent %0d words with %0d computes; checked %0d result words, %0d saturated",
               words_sent, computes, words_seen, sat_seen);
      if (errors == 0 && expected_words.size() == 0)
         $display("polynomial_arithmetic_unit test passed");
      else
         $display("polynomial_arithmetic_unit test failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/pau_pkg.sv
rtl/pau_ram.sv
rtl/pau_dp.sv
rtl/pau_ctrl.sv
rtl/polynomial_arithmetic_unit.sv
bench/polynomial_arithmetic_unit_test.sv
